>>> rtl/core/hda_pkg.sv
// Shared types, op codes and widths for the double-ended hunk allocator.
package hda_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned ALIGN_W = 4;
  // Wide enough for a mark plus a size plus alignment slack plus a partner mark.
  localparam int unsigned SUM_W   = ADDR_W + 3;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [ADDR_W-1:0] POOL_BYTES_RST = 32'd134217728;

  // Temp allocations work in 16-byte granules; low-end ones also take a 16-byte header.
  localparam logic [SUM_W-1:0] GRAN_MASK = SUM_W'(15);
  localparam logic [SUM_W-1:0] HDR_BYTES = SUM_W'(16);

  localparam logic [OP_W-1:0] OP_PERM_LOW   = 4'd0;
  localparam logic [OP_W-1:0] OP_PERM_HIGH  = 4'd1;
  localparam logic [OP_W-1:0] OP_TEMP_LOW   = 4'd2;
  localparam logic [OP_W-1:0] OP_TEMP_HIGH  = 4'd3;
  localparam logic [OP_W-1:0] OP_RESIZE     = 4'd4;
  localparam logic [OP_W-1:0] OP_FREE_TEMP  = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd6;
  localparam logic [OP_W-1:0] OP_CLEAR_MARK = 4'd7;
  localparam logic [OP_W-1:0] OP_SET_MARK   = 4'd8;
  localparam logic [OP_W-1:0] OP_RST_HIGH   = 4'd9;
  localparam logic [OP_W-1:0] OP_RST_LOW    = 4'd10;

  typedef struct packed {
    logic [ADDR_W-1:0]  freed_span;
    logic [ALIGN_W-1:0] align_log2;
    logic [ADDR_W-1:0]  request_bytes;
    logic [OP_W-1:0]    op;
  } item_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] offset;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] low_permanent;
    logic [ADDR_W-1:0] low_temp;
    logic [ADDR_W-1:0] low_saved_mark;
    logic [ADDR_W-1:0] high_permanent;
    logic [ADDR_W-1:0] high_temp;
  } marks_t;

endpackage

>>> rtl/core/double_ended_hunk_allocator_top.sv
// A request is held in the input register until the result register can take its result.
// Throughput: one request per cycle unless out_tready stalls; each op reads the marks
//   the previous op left: add/mask/compare sits between the input and result registers.
// Reset (rst_n low, synchronous): all five marks clear to zero, pool size returns
//   to 128 MiB, both stream stages empty.
// Top level: stream ports, input and result registers, mark and pool registers.
module double_ended_hunk_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration: pool size in bytes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hda_pkg::ADDR_W-1:0]     cfg_data,
  // Requests
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: op[3:0], request_bytes[35:4], align_log2[39:36], freed_span[71:40]
  input  logic [hda_pkg::IN_DATA_W-1:0]  in_tdata,
  // Results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: offset[31:0], span[63:32], status[64], zero pad[71:65]
  output logic [hda_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hda_pkg::*;

  logic              in_valid_r;
  item_t             in_item_r;
  logic              out_valid_r;
  result_t           out_res_r;
  marks_t            marks_r;
  marks_t            marks_nxt;
  result_t           res_nxt;
  logic [ADDR_W-1:0] pool_r;
  logic              advance;

  // The result register frees up when empty or when its transaction completes
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  hda_calc u_calc (
    .item      (in_item_r),
    .marks     (marks_r),
    .pool_bytes(pool_r),
    .marks_nxt (marks_nxt),
    .res       (res_nxt)
  );

  // Capture a request transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= item_t'(in_tdata);
    end
  end

  // Commit marks and register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      marks_r     <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        marks_r <= marks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  // Pool size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      pool_r <= cfg_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule

>>> rtl/core/hda_calc.sv
// Combinational operation logic: next marks and result for one request.
module hda_calc (
  input  hda_pkg::item_t             item,
  input  hda_pkg::marks_t            marks,
  input  logic [hda_pkg::ADDR_W-1:0] pool_bytes,
  output hda_pkg::marks_t            marks_nxt,
  output hda_pkg::result_t           res
);
  import hda_pkg::*;

  logic [SUM_W-1:0] size_w;
  logic [SUM_W-1:0] pool_w;
  logic [SUM_W-1:0] align_m;
  logic [SUM_W-1:0] perm_base;
  logic [SUM_W-1:0] perm_n;
  logic [SUM_W-1:0] tl_z;
  logic [SUM_W-1:0] tl_n;
  logic [SUM_W-1:0] th_n;
  logic [SUM_W-1:0] rs_n;
  logic [SUM_W-1:0] chk_n;
  logic [SUM_W-1:0] chk_partner;
  logic             chk_en;
  logic             crossed;
  logic [ADDR_W-1:0] n32;

  // Widen operands so sums past 2^32 still count as overflow
  assign size_w  = SUM_W'(item.request_bytes);
  assign pool_w  = SUM_W'(pool_bytes);
  assign align_m = (SUM_W'(1) << item.align_log2) - SUM_W'(1);

  // Candidate new marks for each allocating op
  assign perm_base = (item.op == OP_PERM_HIGH) ? SUM_W'(marks.high_permanent)
                                               : SUM_W'(marks.low_permanent);
  assign perm_n = (perm_base + size_w + align_m) & ~align_m;
  assign tl_z   = (SUM_W'(marks.low_temp) + GRAN_MASK) & ~GRAN_MASK;
  assign tl_n   = tl_z + size_w + HDR_BYTES;
  assign th_n   = SUM_W'(marks.high_temp) + ((size_w + GRAN_MASK) & ~GRAN_MASK);
  assign rs_n   = SUM_W'(marks.low_permanent) + size_w;

  // Pick the mark under test and the opposite end it must not cross
  always_comb begin
    chk_n       = '0;
    chk_partner = SUM_W'(marks.high_temp);
    chk_en      = 1'b1;
    case (item.op)
      OP_PERM_LOW: begin
        chk_n = perm_n;
      end
      OP_PERM_HIGH: begin
        chk_n       = perm_n;
        chk_partner = SUM_W'(marks.low_temp);
      end
      OP_TEMP_LOW: begin
        chk_n = tl_n;
      end
      OP_TEMP_HIGH: begin
        chk_n       = th_n;
        chk_partner = SUM_W'(marks.low_temp);
      end
      OP_RESIZE: begin
        chk_n = rs_n;
      end
      default: begin
        chk_en = 1'b0;
      end
    endcase
  end

  assign crossed = chk_en && ((chk_n + chk_partner) > pool_w);
  // A committed mark never exceeds the pool, so it fits the address width
  assign n32 = chk_n[ADDR_W-1:0];

  // Apply the op unless the ends would cross
  always_comb begin
    marks_nxt = marks;
    res       = '0;
    if (crossed) begin
      res.status = 1'b1;
    end else begin
      case (item.op)
        OP_PERM_LOW: begin
          res.offset              = marks.low_permanent;
          marks_nxt.low_permanent = n32;
          marks_nxt.low_temp      = n32;
        end
        OP_PERM_HIGH: begin
          marks_nxt.high_permanent = n32;
          marks_nxt.high_temp      = n32;
          res.offset               = pool_bytes - n32;
        end
        OP_TEMP_LOW: begin
          res.offset         = tl_z[ADDR_W-1:0] + ADDR_W'(16);
          res.span           = n32 - marks.low_temp;
          marks_nxt.low_temp = n32;
        end
        OP_TEMP_HIGH: begin
          marks_nxt.high_temp = n32;
          res.offset          = pool_bytes - n32;
        end
        OP_RESIZE: begin
          marks_nxt.low_temp = n32;
          res.offset         = marks.low_permanent;
        end
        OP_FREE_TEMP: begin
          marks_nxt.low_temp = (item.freed_span > marks.low_temp) ? '0
                               : marks.low_temp - item.freed_span;
        end
        OP_CLEAR: begin
          marks_nxt = '0;
        end
        OP_CLEAR_MARK: begin
          marks_nxt.low_permanent = marks.low_saved_mark;
          marks_nxt.low_temp      = marks.low_saved_mark;
        end
        OP_SET_MARK: begin
          marks_nxt.low_saved_mark = marks.low_permanent;
        end
        OP_RST_HIGH: begin
          marks_nxt.high_temp = marks.high_permanent;
        end
        OP_RST_LOW: begin
          marks_nxt.low_temp = marks.low_permanent;
        end
        default: begin
          marks_nxt = marks;
        end
      endcase
    end
  end

endmodule

>>> test/tb_top.sv
// Self-checking stream testbench for the double-ended hunk allocator.
`timescale 1ns / 100ps

module tb_top;
  import hda_pkg::*;

  localparam int RES_W      = $bits(result_t);
  localparam int DIR_ROWS   = 24;
  localparam int PHASES     = 6;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 4;
  // Codes above the last defined op are spare and must leave the marks alone.
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_RST_LOW + 4'd1;
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  // One row of the directed script; want_* are used only when typed is set.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  req;
    logic [ALIGN_W-1:0] align;
    logic [ADDR_W-1:0]  freed;
    logic               typed;
    logic [ADDR_W-1:0]  want_offset;
    logic [ADDR_W-1:0]  want_span;
    logic               want_status;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ADDR_W-1:0]     cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predicted allocator state
  logic [ADDR_W-1:0] pool_size = POOL_BYTES_RST;
  logic [ADDR_W-1:0] lo_perm = '0;
  logic [ADDR_W-1:0] lo_temp = '0;
  logic [ADDR_W-1:0] lo_mark = '0;
  logic [ADDR_W-1:0] hi_perm = '0;
  logic [ADDR_W-1:0] hi_temp = '0;
  logic [ADDR_W-1:0] last_temp_span = '0;

  result_t pending_results[$];
  result_t got_res, want_res;
  int      fail_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      overflows_seen = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  bit      long_hold_req = 1'b0;
  int      hold_left = 0;
  int      stall_mode = 0;
  int      mode_left = 0;

  double_ended_hunk_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit ends_cross(logic [63:0] a, logic [63:0] b);
    return (a + b) > 64'(pool_size);
  endfunction

  // Advance the predicted marks by one request and return its result.
  function automatic result_t apply_hunk_op(item_t it);
    result_t    res;
    logic [63:0] sz, al, nxt, base16;
    res = '0;
    sz  = 64'(it.request_bytes);
    al  = 64'd1 << it.align_log2;
    case (it.op)
      OP_PERM_LOW: begin
        nxt = (64'(lo_perm) + sz + al - 64'd1) & ~(al - 64'd1);
        if (ends_cross(nxt, 64'(hi_temp))) res.status = 1'b1;
        else begin
          res.offset = lo_perm;
          lo_perm = nxt[ADDR_W-1:0];
          lo_temp = nxt[ADDR_W-1:0];
        end
      end
      OP_PERM_HIGH: begin
        nxt = (64'(hi_perm) + sz + al - 64'd1) & ~(al - 64'd1);
        if (ends_cross(nxt, 64'(lo_temp))) res.status = 1'b1;
        else begin
          hi_perm = nxt[ADDR_W-1:0];
          hi_temp = nxt[ADDR_W-1:0];
          res.offset = pool_size - nxt[ADDR_W-1:0];
        end
      end
      OP_TEMP_LOW: begin
        base16 = (64'(lo_temp) + 64'd15) & ~64'd15;
        nxt = base16 + sz + 64'd16;
        if (ends_cross(nxt, 64'(hi_temp))) res.status = 1'b1;
        else begin
          res.offset = ADDR_W'(base16 + 64'd16);
          res.span = ADDR_W'(nxt - 64'(lo_temp));
          last_temp_span = res.span;
          lo_temp = nxt[ADDR_W-1:0];
        end
      end
      OP_TEMP_HIGH: begin
        nxt = 64'(hi_temp) + ((sz + 64'd15) & ~64'd15);
        if (ends_cross(nxt, 64'(lo_temp))) res.status = 1'b1;
        else begin
          hi_temp = nxt[ADDR_W-1:0];
          res.offset = pool_size - nxt[ADDR_W-1:0];
        end
      end
      OP_RESIZE: begin
        nxt = 64'(lo_perm) + sz;
        if (ends_cross(nxt, 64'(hi_temp))) res.status = 1'b1;
        else begin
          lo_temp = nxt[ADDR_W-1:0];
          res.offset = lo_perm;
        end
      end
      OP_FREE_TEMP: lo_temp = (it.freed_span > lo_temp) ? '0 : lo_temp - it.freed_span;
      OP_CLEAR: begin
        lo_perm = '0;
        lo_temp = '0;
        lo_mark = '0;
        hi_perm = '0;
        hi_temp = '0;
      end
      OP_CLEAR_MARK: begin
        lo_perm = lo_mark;
        lo_temp = lo_mark;
      end
      OP_SET_MARK: lo_mark = lo_perm;
      OP_RST_HIGH: hi_temp = hi_perm;
      OP_RST_LOW: lo_temp = lo_perm;
      default: ;
    endcase
    return res;
  endfunction

  // Build a random request scaled to the current pool size.
  function automatic item_t make_request(logic [ADDR_W-1:0] pool);
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 14)      it.op = OP_PERM_LOW;
    else if (pick < 24) it.op = OP_PERM_HIGH;
    else if (pick < 42) it.op = OP_TEMP_LOW;
    else if (pick < 54) it.op = OP_TEMP_HIGH;
    else if (pick < 62) it.op = OP_RESIZE;
    else if (pick < 73) it.op = OP_FREE_TEMP;
    else if (pick < 75) it.op = OP_CLEAR;
    else if (pick < 79) it.op = OP_CLEAR_MARK;
    else if (pick < 85) it.op = OP_SET_MARK;
    else if (pick < 90) it.op = OP_RST_HIGH;
    else if (pick < 96) it.op = OP_RST_LOW;
    else                it.op = OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
    // Mostly sizes that fit a few dozen times, with wild ones mixed in
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.request_bytes = $urandom_range(0, pool >> 5);
      4:          it.request_bytes = $urandom_range(0, 64);
      5:          it.request_bytes = $urandom;
      6: begin
        case ($urandom_range(0, 2))
          0:       it.request_bytes = '0;
          1:       it.request_bytes = '1;
          default: it.request_bytes = pool;
        endcase
      end
      7, 8:       it.request_bytes = $urandom_range(0, pool >> 2);
      default:    it.request_bytes = $urandom_range(0, pool);
    endcase
    it.align_log2 = ($urandom_range(0, 9) == 0) ? ALIGN_W'($urandom_range(0, 15))
                                                : ALIGN_W'($urandom_range(0, 12));
    // Free usually gives back the span of the last temp allocation
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: it.freed_span = last_temp_span;
      6, 7:             it.freed_span = $urandom_range(0, 256);
      8:                it.freed_span = $urandom;
      default:          it.freed_span = '1;
    endcase
    return it;
  endfunction

  // Offer one request in bursts with random gaps; record its expected result.
  task automatic offer_request(input item_t it, input bit typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predicted = apply_hunk_op(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and wait until every result is back.
  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool(input logic [ADDR_W-1:0] bytes);
    cfg_valid <= 1'b1;
    cfg_data  <= bytes;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_size = bytes;
  endtask

  // Receiver: stall on changing duty patterns, with occasional long hold-offs.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 2999) == 0) hold_left = 150;
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata[RES_W-1:0]);
      results_seen++;
      if (got_res.status) overflows_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: offset %h span %h status %b",
               got_res.offset, got_res.span, got_res.status);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.offset !== want_res.offset) begin
          $error("offset: expected %h, got %h", want_res.offset, got_res.offset);
          fail_count++;
        end
        if (got_res.span !== want_res.span) begin
          $error("span: expected %h, got %h", want_res.span, got_res.span);
          fail_count++;
        end
        if (got_res.status !== want_res.status) begin
          $error("status: expected %b, got %b", want_res.status, got_res.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d results still pending", pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    row_t              rows [DIR_ROWS];
    logic [ADDR_W-1:0] pool_plan [PHASES];
    int                phase_items [PHASES];
    item_t             it;
    result_t           typed_res;

    // op, request, align, freed, typed, offset, span, status (default pool)
    rows = '{
      '{OP_PERM_LOW,   32'd100,       4'd4,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_PERM_LOW,   32'hFFFF_FFFF, 4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b1},
      '{OP_PERM_HIGH,  32'h20,        4'd5,  32'd0,   1'b1, 32'h07FF_FFE0, 32'd0, 1'b0},
      '{OP_TEMP_LOW,   32'd0,         4'd0,  32'd0,   1'b1, 32'd128,     32'd16, 1'b0},
      '{OP_TEMP_LOW,   32'hFFFF_FFFF, 4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b1},
      '{OP_TEMP_HIGH,  32'd1,         4'd0,  32'd0,   1'b1, 32'h07FF_FFD0, 32'd0, 1'b0},
      '{OP_TEMP_HIGH,  32'hFFFF_FFFF, 4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b1},
      '{OP_RESIZE,     32'h40,        4'd0,  32'd0,   1'b0, 32'd0,       32'd0,  1'b0},
      // free more than is held: low temp saturates at zero
      '{OP_FREE_TEMP,  32'd0,         4'd0,  '1,      1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_RST_LOW,    32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_SET_MARK,   32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_PERM_LOW,   32'd7,         4'd12, 32'd0,   1'b0, 32'd0,       32'd0,  1'b0},
      '{OP_CLEAR_MARK, 32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_RST_HIGH,   32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      // spare op code with every field at its top value
      '{OP_SPARE_HI,   '1,            '1,    '1,      1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_PERM_LOW,   32'd0,         4'd15, 32'd0,   1'b0, 32'd0,       32'd0,  1'b0},
      '{OP_FREE_TEMP,  32'd0,         4'd0,  32'd16,  1'b0, 32'd0,       32'd0,  1'b0},
      '{OP_TEMP_LOW,   32'd5,         4'd0,  32'd0,   1'b0, 32'd0,       32'd0,  1'b0},
      '{OP_CLEAR,      32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      // high end takes the whole pool exactly, then nothing more fits
      '{OP_PERM_HIGH,  POOL_BYTES_RST, 4'd0, 32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_TEMP_LOW,   32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b1},
      '{OP_FREE_TEMP,  32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_CLEAR,      32'd0,         4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b0},
      '{OP_RESIZE,     32'hFFFF_FFFF, 4'd0,  32'd0,   1'b1, 32'd0,       32'd0,  1'b1}
    };
    pool_plan   = '{POOL_BYTES_RST, 32'd0, 32'hFFFF_FFFF, 32'd4096, 32'h0010_0000, $urandom};
    phase_items = '{400, 60, 400, 350, 350, 340};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script at the reset pool size
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.op            = rows[r].op;
      it.request_bytes = rows[r].req;
      it.align_log2    = rows[r].align;
      it.freed_span    = rows[r].freed;
      typed_res.offset = rows[r].want_offset;
      typed_res.span   = rows[r].want_span;
      typed_res.status = rows[r].want_status;
      offer_request(it, rows[r].typed, typed_res);
    end

    // Random phases, each on its own pool size and starting from a clean pool
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        write_pool(pool_plan[p]);
      end
      if (p == 2) long_hold_req = 1'b1;
      it = '0;
      it.op = OP_CLEAR;
      offer_request(it, 1'b0, '0);
      for (int n = 1; n < phase_items[p]; n++)
        offer_request(make_request(pool_size), 1'b0, '0);
    end

    drain();
    $display("covered %0d requests over %0d pool sizes, zero and full-range included",
             items_sent, PHASES);
    $display("checked %0d results, %0d of them overflows", results_seen, overflows_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hda_pkg.sv
rtl/core/hda_calc.sv
rtl/core/double_ended_hunk_allocator_top.sv
test/tb_top.sv
